// ===== rtl/lrlb_pkg.sv =====
// Shared types and constants of the line ring log buffer.
package lrlb_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_LINE = 1'b1;

  typedef logic [AW-1:0]     pos_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_PREV  = 2'd1,
    FUNC_NEXT  = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic {
    DIR_UP   = 1'b0,
    DIR_DOWN = 1'b1
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_STORE,
    ST_WR_OLD,
    ST_WR_RD,
    ST_SCAN_A,
    ST_EVAL_A,
    ST_SCAN_B,
    ST_EVAL_B,
    ST_RD_WAIT,
    ST_RD_EVAL
  } state_e;

  typedef struct packed {
    logic  we;
    pos_t  addr;
    byte_t data;
  } mem_wr_t;

endpackage

// ===== rtl/line_ring_log_buffer.sv =====
// Top level of the line ring log buffer: sequencer, positions, marker register and result beat.
// A write stores the byte and moves the oldest and read positions on if the write position meets
// them; newline bytes are dropped. Line moves read through the registered store port until a marker
// or a bound ends the walk. A byte read walks to the offset, stops at a marker, answers at once past the limit.
// One item at a time, busy_o high meanwhile; the next beat may go in at the edge that takes the
// result, which lasts one cycle and cannot be stalled. Reset: write 1, read and oldest 0, marker 0.
module line_ring_log_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [9:0]  offset_i,
  input  logic [9:0]  read_limit_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        done_o,
  output logic        status_o,
  output logic [9:0]  line_length_o,
  output logic [7:0]  read_byte_o
);

  lrlb_pkg::state_e state_q, state_d;
  lrlb_pkg::pos_t   wp_q, wp_d;
  lrlb_pkg::pos_t   oldest_q, oldest_d;
  lrlb_pkg::pos_t   rp_q, rp_d;
  lrlb_pkg::pos_t   cur_q, cur_d;
  lrlb_pkg::pos_t   n_q, n_d;
  lrlb_pkg::byte_t  marker_q;

  lrlb_pkg::func_e  func_q, func_d;
  lrlb_pkg::byte_t  data_q, data_d;
  logic [9:0]       off_q, off_d;

  logic                       done_q, done_d;
  logic                       status_q, status_d;
  logic [lrlb_pkg::LEN_W-1:0] len_q, len_d;
  lrlb_pkg::byte_t            byte_q, byte_d;

  lrlb_pkg::mem_wr_t mem_wr;
  lrlb_pkg::byte_t   rdata;
  lrlb_pkg::pos_t    unit_pos, unit_next;
  lrlb_pkg::dir_e    unit_dir;

  logic accept;
  logic hit;
  logic is_prev;
  logic prev_stop;

  assign accept    = start_i && !busy_o;
  assign hit       = (rdata == marker_q);
  assign is_prev   = (func_q == lrlb_pkg::FUNC_PREV);
  // Backward walk ends on a marker or at the oldest byte, whichever comes first.
  assign prev_stop = hit || (cur_q == oldest_q);

  lrlb_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mem_wr),
    .raddr_i (cur_q),
    .rdata_o (rdata)
  );

  lrlb_ptr_unit u_ptr (
    .pos_i (unit_pos),
    .dir_i (unit_dir),
    .pos_o (unit_next)
  );

  // Steer the one stepper to whichever position this state advances.
  always_comb begin
    unit_pos = cur_q;
    unit_dir = lrlb_pkg::DIR_UP;
    unique case (state_q)
      lrlb_pkg::ST_WR_STORE: unit_pos = wp_q;
      lrlb_pkg::ST_WR_OLD:   unit_pos = oldest_q;
      lrlb_pkg::ST_WR_RD:    unit_pos = rp_q;
      lrlb_pkg::ST_EVAL_A:   unit_dir = is_prev ? lrlb_pkg::DIR_DOWN : lrlb_pkg::DIR_UP;
      lrlb_pkg::ST_EVAL_B:   unit_dir = (is_prev && !prev_stop) ? lrlb_pkg::DIR_DOWN
                                                                : lrlb_pkg::DIR_UP;
      default:               unit_pos = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lrlb_pkg::ST_IDLE;
      wp_q     <= lrlb_pkg::AW'(1);
      oldest_q <= '0;
      rp_q     <= '0;
      marker_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      oldest_q <= oldest_d;
      rp_q     <= rp_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

  // Working and result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    n_q      <= n_d;
    func_q   <= func_d;
    data_q   <= data_d;
    off_q    <= off_d;
    status_q <= status_d;
    len_q    <= len_d;
    byte_q   <= byte_d;
  end

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    oldest_d = oldest_q;
    rp_d     = rp_q;
    cur_d    = cur_q;
    n_d      = n_q;
    func_d   = func_q;
    data_d   = data_q;
    off_d    = off_q;
    done_d   = 1'b0;
    status_d = status_q;
    len_d    = len_q;
    byte_d   = byte_q;
    mem_wr   = '{we: 1'b0, addr: wp_q, data: data_q};

    unique case (state_q)
      lrlb_pkg::ST_IDLE: begin
        if (accept) begin
          func_d   = lrlb_pkg::func_e'(func_i);
          data_d   = data_byte_i;
          off_d    = offset_i;
          cur_d    = rp_q;
          n_d      = '0;
          status_d = lrlb_pkg::STATUS_OK;
          len_d    = '0;
          byte_d   = '0;
          unique case (lrlb_pkg::func_e'(func_i))
            lrlb_pkg::FUNC_WRITE: state_d = lrlb_pkg::ST_WR_STORE;
            lrlb_pkg::FUNC_PREV,
            lrlb_pkg::FUNC_NEXT:  state_d = lrlb_pkg::ST_SCAN_A;
            lrlb_pkg::FUNC_READ: begin
              // Past the limit: answer zero at once.
              if (offset_i >= read_limit_i) begin
                done_d = 1'b1;
              end else begin
                state_d = lrlb_pkg::ST_RD_WAIT;
              end
            end
            default: state_d = lrlb_pkg::ST_IDLE;
          endcase
        end
      end

      lrlb_pkg::ST_WR_STORE: begin
        // Drop newline bytes without touching the ring.
        if (data_q == lrlb_pkg::NEWLINE_BYTE) begin
          done_d  = 1'b1;
          state_d = lrlb_pkg::ST_IDLE;
        end else begin
          mem_wr.we = 1'b1;
          wp_d      = unit_next;
          state_d   = lrlb_pkg::ST_WR_OLD;
        end
      end

      lrlb_pkg::ST_WR_OLD: begin
        if (wp_q == oldest_q) begin
          oldest_d = unit_next;
        end
        state_d = lrlb_pkg::ST_WR_RD;
      end

      lrlb_pkg::ST_WR_RD: begin
        if (wp_q == rp_q) begin
          rp_d = unit_next;
        end
        done_d  = 1'b1;
        state_d = lrlb_pkg::ST_IDLE;
      end

      lrlb_pkg::ST_SCAN_A: begin
        // Hitting the bound before a marker means no complete line.
        if (cur_q == (is_prev ? oldest_q : wp_q)) begin
          status_d = lrlb_pkg::STATUS_NO_LINE;
          done_d   = 1'b1;
          state_d  = lrlb_pkg::ST_IDLE;
        end else begin
          state_d = lrlb_pkg::ST_EVAL_A;
        end
      end

      lrlb_pkg::ST_EVAL_A: begin
        cur_d = unit_next;
        if (hit) begin
          n_d = '0;
          // Forward move commits the new read position even if the line stays open.
          if (!is_prev) begin
            rp_d = unit_next;
          end
          state_d = lrlb_pkg::ST_SCAN_B;
        end else begin
          state_d = lrlb_pkg::ST_SCAN_A;
        end
      end

      lrlb_pkg::ST_SCAN_B: begin
        if (!is_prev && (cur_q == wp_q)) begin
          status_d = lrlb_pkg::STATUS_NO_LINE;
          done_d   = 1'b1;
          state_d  = lrlb_pkg::ST_IDLE;
        end else begin
          state_d = lrlb_pkg::ST_EVAL_B;
        end
      end

      lrlb_pkg::ST_EVAL_B: begin
        if (is_prev) begin
          if (prev_stop) begin
            done_d  = 1'b1;
            state_d = lrlb_pkg::ST_IDLE;
            if (!hit) begin
              status_d = lrlb_pkg::STATUS_NO_LINE;
            end else begin
              len_d = lrlb_pkg::LEN_W'(n_q);
              // An empty line leaves the read position on its leading marker.
              rp_d  = (n_q != '0) ? unit_next : cur_q;
            end
          end else begin
            cur_d   = unit_next;
            n_d     = n_q + 1'b1;
            state_d = lrlb_pkg::ST_SCAN_B;
          end
        end else begin
          if (hit) begin
            len_d   = lrlb_pkg::LEN_W'(n_q);
            done_d  = 1'b1;
            state_d = lrlb_pkg::ST_IDLE;
          end else begin
            cur_d   = unit_next;
            n_d     = n_q + 1'b1;
            state_d = lrlb_pkg::ST_SCAN_B;
          end
        end
      end

      lrlb_pkg::ST_RD_WAIT: state_d = lrlb_pkg::ST_RD_EVAL;

      lrlb_pkg::ST_RD_EVAL: begin
        // A marker on the way, or at the target, reads as zero.
        if (hit) begin
          done_d  = 1'b1;
          state_d = lrlb_pkg::ST_IDLE;
        end else if (n_q == lrlb_pkg::AW'(off_q)) begin
          byte_d  = rdata;
          done_d  = 1'b1;
          state_d = lrlb_pkg::ST_IDLE;
        end else begin
          cur_d   = unit_next;
          n_d     = n_q + 1'b1;
          state_d = lrlb_pkg::ST_RD_WAIT;
        end
      end

      default: state_d = lrlb_pkg::ST_IDLE;
    endcase
  end

  assign busy_o        = (state_q != lrlb_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign line_length_o = len_q;
  assign read_byte_o   = byte_q;

`ifndef SYNTHESIS
  // An accepted beat either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted beat neither answered nor started");

  // A result beat only follows work in progress or a fresh acceptance.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) || $past(accept)))
    else $error("result beat without a cause");

  // Between items the write position never sits on the oldest byte.
  a_ring_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (wp_q != oldest_q))
    else $error("write position caught the oldest position");

  // No-line results carry zero length and a zero byte.
  a_no_line_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (line_length_o == '0) && (read_byte_o == '0))
    else $error("no-line result with payload");
`endif

endmodule

// ===== rtl/lrlb_mem.sv =====
// Text store: single write port, registered read port, entry 0 reads as zero until written.
module lrlb_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrlb_pkg::mem_wr_t wr_i,
  input  lrlb_pkg::pos_t   raddr_i,
  output lrlb_pkg::byte_t  rdata_o
);

  lrlb_pkg::byte_t mem [lrlb_pkg::DEPTH];
  lrlb_pkg::byte_t rdata_q;
  logic            e0_valid_q;
  logic            hit0_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  // Entry 0 holds the reset marker (zero) until the ring first wraps onto it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_valid_q <= 1'b0;
      hit0_q     <= 1'b0;
    end else begin
      if (wr_i.we && (wr_i.addr == '0)) begin
        e0_valid_q <= 1'b1;
      end
      hit0_q <= (raddr_i == '0) && !e0_valid_q;
    end
  end

  assign rdata_o = hit0_q ? '0 : rdata_q;

endmodule

// ===== rtl/lrlb_ptr_unit.sv =====
// Shared ring position stepper: one place forward or back, wrapping at the store depth.
module lrlb_ptr_unit (
  input  lrlb_pkg::pos_t pos_i,
  input  lrlb_pkg::dir_e dir_i,
  output lrlb_pkg::pos_t pos_o
);

  localparam lrlb_pkg::pos_t LastPos = lrlb_pkg::AW'(lrlb_pkg::DEPTH - 1);

  always_comb begin
    unique case (dir_i)
      lrlb_pkg::DIR_UP:   pos_o = (pos_i == LastPos) ? '0 : pos_i + 1'b1;
      lrlb_pkg::DIR_DOWN: pos_o = (pos_i == '0) ? LastPos : pos_i - 1'b1;
      default:            pos_o = pos_i;
    endcase
  end

endmodule

// ===== sim/line_ring_log_buffer_checker.sv =====
// Checker for the line ring log buffer: shadow log store, results due and field comparison.
module line_ring_log_buffer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic [9:0]  offset_i,
  input  logic [9:0]  read_limit_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        done_i,
  input  logic        status_i,
  input  logic [9:0]  line_length_i,
  input  logic [7:0]  read_byte_i,
  output int unsigned mismatches_o,
  output int unsigned beats_due_o
);

  typedef struct packed {
    logic            status;
    logic [9:0]      len;
    lrlb_pkg::byte_t rbyte;
  } outcome_t;

  lrlb_pkg::byte_t shadow_text [lrlb_pkg::DEPTH];
  lrlb_pkg::pos_t  wr_pos;
  lrlb_pkg::pos_t  old_pos;
  lrlb_pkg::pos_t  rd_pos;
  lrlb_pkg::byte_t eol;
  outcome_t        outcomes_due [$];
  outcome_t        head;
  int unsigned     mismatch_cnt;
  int unsigned     due_cnt;

  assign mismatches_o = mismatch_cnt;
  assign beats_due_o  = due_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Apply one op to the shadow store and return the beat it must produce.
  function automatic outcome_t log_outcome(input lrlb_pkg::func_e op,
                                           input lrlb_pkg::byte_t din,
                                           input logic [9:0] off, input logic [9:0] lim);
    outcome_t       res;
    lrlb_pkg::pos_t e;
    lrlb_pkg::pos_t b;
    lrlb_pkg::pos_t p;
    int unsigned    n;
    int unsigned    steps;
    int unsigned    i;
    logic           hit;
    res = '0;
    case (op)
      lrlb_pkg::FUNC_WRITE: begin
        if (din != lrlb_pkg::NEWLINE_BYTE) begin
          shadow_text[wr_pos] = din;
          wr_pos = wr_pos + 1'b1;
          if (wr_pos == old_pos) old_pos = old_pos + 1'b1;
          if (wr_pos == rd_pos) rd_pos = rd_pos + 1'b1;
        end
      end
      lrlb_pkg::FUNC_PREV: begin
        // find the marker that ends the previous line, then the one before it
        e = rd_pos;
        steps = 0;
        while (e != old_pos && shadow_text[e] != eol && steps < lrlb_pkg::DEPTH) begin
          e = e - 1'b1;
          steps++;
        end
        if (e == old_pos) begin
          res.status = lrlb_pkg::STATUS_NO_LINE;
        end else begin
          b = e - 1'b1;
          n = 0;
          steps = 0;
          while (b != old_pos && shadow_text[b] != eol && steps < lrlb_pkg::DEPTH) begin
            b = b - 1'b1;
            n++;
            steps++;
          end
          if (shadow_text[b] != eol) begin
            res.status = lrlb_pkg::STATUS_NO_LINE;
          end else begin
            // an empty line leaves the read position on the marker before it
            if (n != 0) b = b + 1'b1;
            rd_pos  = b;
            res.len = n[9:0];
          end
        end
      end
      lrlb_pkg::FUNC_NEXT: begin
        b = rd_pos;
        steps = 0;
        while (b != wr_pos && shadow_text[b] != eol && steps < lrlb_pkg::DEPTH) begin
          b = b + 1'b1;
          steps++;
        end
        if (b == wr_pos) begin
          res.status = lrlb_pkg::STATUS_NO_LINE;
        end else begin
          b = b + 1'b1;
          e = b;
          n = 0;
          steps = 0;
          while (e != wr_pos && shadow_text[e] != eol && steps < lrlb_pkg::DEPTH) begin
            e = e + 1'b1;
            n++;
            steps++;
          end
          // the read position moves even when the next line is unterminated
          rd_pos = b;
          if (e == wr_pos) res.status = lrlb_pkg::STATUS_NO_LINE;
          else res.len = n[9:0];
        end
      end
      default: begin
        if (off < lim) begin
          p = rd_pos;
          hit = 1'b0;
          for (i = 0; i < off && !hit; i++) begin
            if (shadow_text[p] == eol) hit = 1'b1;
            else p = p + 1'b1;
          end
          if (!hit && shadow_text[p] != eol) res.rbyte = shadow_text[p];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lrlb_pkg::DEPTH; k++) shadow_text[k] = '0;
      wr_pos  = lrlb_pkg::pos_t'(1);
      old_pos = '0;
      rd_pos  = '0;
      eol     = '0;
      outcomes_due.delete();
      mismatch_cnt = 0;
      due_cnt      = 0;
    end else begin
      // retire the oldest beat before taking a new op on the same edge
      if (done_i) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result beat with nothing due",
                          {13'b0, status_i, line_length_i, read_byte_i}, '0);
        end else begin
          head = outcomes_due.pop_front();
          if (status_i !== head.status)
            report_mismatch("status", 32'(status_i), 32'(head.status));
          if (line_length_i !== head.len)
            report_mismatch("line_length", 32'(line_length_i), 32'(head.len));
          if (read_byte_i !== head.rbyte)
            report_mismatch("read_byte", 32'(read_byte_i), 32'(head.rbyte));
        end
      end
      if (cfg_we_i) eol = cfg_wdata_i;
      if (start_i && !busy_i)
        outcomes_due.push_back(log_outcome(lrlb_pkg::func_e'(func_i), data_byte_i,
                                           offset_i, read_limit_i));
      due_cnt = outcomes_due.size();
    end
  end

endmodule

// ===== sim/line_ring_log_buffer_tb.sv =====
// Testbench top for the line ring log buffer: clock, reset, op stimulus and the verdict.
module line_ring_log_buffer_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [7:0]  data_byte_i;
  logic [9:0]  offset_i;
  logic [9:0]  read_limit_i;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        done_o;
  logic        status_o;
  logic [9:0]  line_length_o;
  logic [7:0]  read_byte_o;

  int unsigned mismatches;
  int unsigned beats_due;

  // percentage of cycles in which the feeder holds its next op back
  int unsigned     gap_pct;
  // ops that reach the block (dropped newline writes are not counted)
  int unsigned     ops_sent;
  // bytes actually stored; once DEPTH-1 have gone in, every entry holds data
  int unsigned     bytes_stored;
  lrlb_pkg::byte_t cur_eol;

  line_ring_log_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .data_byte_i   (data_byte_i),
    .offset_i      (offset_i),
    .read_limit_i  (read_limit_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .line_length_o (line_length_o),
    .read_byte_o   (read_byte_o)
  );

  line_ring_log_buffer_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .func_i        (func_i),
    .data_byte_i   (data_byte_i),
    .offset_i      (offset_i),
    .read_limit_i  (read_limit_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .line_length_i (line_length_o),
    .read_byte_i   (read_byte_o),
    .mismatches_o  (mismatches),
    .beats_due_o   (beats_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: sized for every op walking the whole store with the feeder idling, several
  // times over.
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Present one op from a falling edge and hold it until the block takes the beat. Start is
  // left high after the accepting edge; the next falling edge either brings the next op or
  // drops start, so it is never lowered and raised in the same step.
  task automatic push_op(input lrlb_pkg::func_e op, input lrlb_pkg::byte_t din,
                         input logic [9:0] off, input logic [9:0] lim);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= op;
    data_byte_i  <= din;
    offset_i     <= off;
    read_limit_i <= lim;
    do @(posedge clk_i); while (busy_o);
    if (op != lrlb_pkg::FUNC_WRITE || din != lrlb_pkg::NEWLINE_BYTE) ops_sent++;
    if (op == lrlb_pkg::FUNC_WRITE && din != lrlb_pkg::NEWLINE_BYTE) bytes_stored++;
  endtask

  // Feed one log line byte by byte, then close it with the current marker. Now and then a
  // newline byte slips in, which the block must drop.
  task automatic write_line(input int unsigned len);
    lrlb_pkg::byte_t ch;
    repeat (len) begin
      ch = ($urandom_range(15) == 0) ? lrlb_pkg::NEWLINE_BYTE
                                     : lrlb_pkg::byte_t'($urandom_range(255));
      push_op(lrlb_pkg::FUNC_WRITE, ch, 10'($urandom), 10'($urandom));
    end
    push_op(lrlb_pkg::FUNC_WRITE, cur_eol, 10'($urandom), 10'($urandom));
  endtask

  // Drop start and hold until every beat due has come back and the block is idle.
  task automatic drain_log();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (beats_due != 0 || busy_o) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_marker(input lrlb_pkg::byte_t value);
    drain_log();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cur_eol     = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed traffic: whole lines, bursts of line moves and byte reads on the line
  // under the read position, with a thin layer of fully random ops. Offsets stay short apart
  // from the odd long one, since a read walks the store entry by entry.
  task automatic mixed_log_traffic(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    logic [9:0]  off;
    logic [9:0]  lim;
    goal = ops_sent + n;
    while (ops_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        write_line(($urandom_range(11) == 0) ? $urandom_range(200) : $urandom_range(10));
      end else if (pick < 45) begin
        repeat ($urandom_range(4, 1))
          push_op(lrlb_pkg::FUNC_PREV, lrlb_pkg::byte_t'($urandom), 10'($urandom),
                  10'($urandom));
      end else if (pick < 65) begin
        repeat ($urandom_range(4, 1))
          push_op(lrlb_pkg::FUNC_NEXT, lrlb_pkg::byte_t'($urandom), 10'($urandom),
                  10'($urandom));
      end else if (pick < 94) begin
        repeat ($urandom_range(4, 1)) begin
          off = ($urandom_range(15) == 0) ? 10'($urandom) : 10'($urandom_range(24));
          lim = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(32));
          push_op(lrlb_pkg::FUNC_READ, lrlb_pkg::byte_t'($urandom), off, lim);
        end
      end else begin
        push_op(lrlb_pkg::func_e'($urandom_range(3)), lrlb_pkg::byte_t'($urandom),
                10'($urandom), 10'($urandom));
      end
    end
  endtask

  initial begin
    lrlb_pkg::byte_t eol_plan [4];
    int unsigned     gap_plan [4];
    lrlb_pkg::byte_t mk;
    logic [9:0]      off;
    logic [9:0]      lim;
    int unsigned     per_phase;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = lrlb_pkg::FUNC_WRITE;
    data_byte_i  = '0;
    offset_i     = '0;
    read_limit_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    gap_pct      = 0;
    ops_sent     = 0;
    bytes_stored = 0;
    cur_eol      = 8'h00;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fresh store: only entry 0 (a marker) holds data at first, so every access stays on written entries.
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);   // read position is the oldest
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd0, 10'd1);   // byte at a marker reads as zero
    push_op(lrlb_pkg::FUNC_READ, 8'hFF, 10'd1023, 10'd1023);  // offset at the limit
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_WRITE, 8'hFF, 10'd1023, 10'd1023);
    push_op(lrlb_pkg::FUNC_WRITE, lrlb_pkg::NEWLINE_BYTE, 10'd0, 10'd0);   // dropped
    push_op(lrlb_pkg::FUNC_WRITE, 8'h41, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_WRITE, 8'h00, 10'd0, 10'd0);  // close the line
    push_op(lrlb_pkg::FUNC_NEXT, 8'h00, 10'd0, 10'd0);   // onto the two-byte line
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd0, 10'd5);
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd1, 10'd5);
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd3, 10'd5);   // runs over the marker
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);   // walks back into the oldest entry
    push_op(lrlb_pkg::FUNC_WRITE, 8'h00, 10'd0, 10'd0);  // empty line
    push_op(lrlb_pkg::FUNC_NEXT, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);   // empty line: park on the marker
    push_op(lrlb_pkg::FUNC_NEXT, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_NEXT, 8'h00, 10'd0, 10'd0);   // unterminated: moves, no line

    // Fill the whole store before any op may reach past the write position. Until then
    // only writes, next-line moves and reads cut off by their limit are sent.
    while (bytes_stored < lrlb_pkg::DEPTH - 1) begin
      if ($urandom_range(9) < 8) begin
        write_line($urandom_range(40));
      end else if ($urandom_range(1) == 1) begin
        push_op(lrlb_pkg::FUNC_NEXT, lrlb_pkg::byte_t'($urandom), 10'($urandom),
                10'($urandom));
      end else begin
        lim = 10'($urandom);
        off = 10'($urandom_range(1023, lim));
        push_op(lrlb_pkg::FUNC_READ, lrlb_pkg::byte_t'($urandom), off, lim);
      end
    end

    // Wrapped store: the oldest position now chases the write position.
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_NEXT, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd0, 10'd1023);
    push_op(lrlb_pkg::FUNC_READ, 8'h00, 10'd1022, 10'd1023);  // long walk, stops at a marker
    push_op(lrlb_pkg::FUNC_WRITE, 8'h00, 10'd0, 10'd0);
    push_op(lrlb_pkg::FUNC_PREV, 8'h00, 10'd0, 10'd0);

    // Random phases, each under its own marker and feeder pacing. Keep newline out of the
    // random markers: it could never be stored, so every search would walk the whole store.
    mk = lrlb_pkg::byte_t'($urandom_range(254, 1));
    if (mk == lrlb_pkg::NEWLINE_BYTE) mk = 8'h5A;
    eol_plan[0] = 8'h00;
    eol_plan[1] = 8'hFF;
    eol_plan[2] = mk;
    mk = lrlb_pkg::byte_t'($urandom_range(254, 1));
    if (mk == lrlb_pkg::NEWLINE_BYTE) mk = 8'hA5;
    eol_plan[3] = mk;
    gap_plan[0] = 0;
    gap_plan[1] = 56;
    gap_plan[2] = 0;
    gap_plan[3] = 16;
    // Split what is left of the run's budget of about 1650 ops over the phases.
    per_phase = (ops_sent < 1650) ? (1650 - ops_sent) / 4 : 0;
    for (int k = 0; k < 4; k++) begin
      set_marker(eol_plan[k]);
      gap_pct = gap_plan[k];
      mixed_log_traffic(per_phase);
    end

    drain_log();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
